// ===== rtl/bis_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bounded integer set.
// No dependencies; imported by bis_ctrl, bounded_integer_set and the bench.
package bis_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int IN_VALUE_W     = 32;
    localparam int COUNT_FIELD_W  = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_SHIFT = 2'd2,
        S_DONE  = 2'd3
    } t_state;

    typedef struct packed {
        t_status                    status;
        logic                       is_member;
        logic [COUNT_FIELD_W-1:0]   element_count;
        logic                       is_empty;
    } t_result;

endpackage

// ===== rtl/bis_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bis_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the set: scans entries through one compare, shifts on remove.
// Depends on bis_pkg; drives the entry RAM through its ports.
module bis_ctrl
    import bis_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_vld,
    output logic                         o_in_rdy,
    input  t_op                          i_opcode,
    input  logic signed [IN_VALUE_W-1:0] i_value,
    output logic                         o_res_vld,
    input  logic                         i_res_rdy,
    output t_result                      o_res,
    output logic                         o_ram_we,
    output logic [AW-1:0]                o_ram_waddr,
    output logic [VALUE_BITS-1:0]        o_ram_wdata,
    output logic [AW-1:0]                o_ram_raddr,
    input  logic [VALUE_BITS-1:0]        i_ram_rdata
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_chk, n_chk;
    logic [AW-1:0]         r_chk_idx, n_chk_idx;
    t_op                   r_op, n_op;
    logic [VALUE_BITS-1:0] r_val, n_val;
    t_status               r_status, n_status;
    logic                  r_member, n_member;

    logic w_issue, w_hit, w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_chk   <= n_chk;
        end
        r_chk_idx <= n_chk_idx;
        r_op      <= n_op;
        r_val     <= n_val;
        r_status  <= n_status;
        r_member  <= n_member;
    end

    // one read issued per cycle; r_chk marks data returning for r_chk_idx
    assign w_issue = (r_idx < r_count);
    assign w_hit   = r_chk && (i_ram_rdata == r_val);
    assign w_end   = !r_chk && (r_idx >= r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_op        = r_op;
        n_val       = r_val;
        n_status    = r_status;
        n_member    = r_member;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_count[AW-1:0];
        o_ram_wdata = r_val;
        o_ram_raddr = r_idx[AW-1:0];
        o_res_vld   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_vld) begin
                    n_op    = i_opcode;
                    n_val   = VALUE_BITS'(i_value);
                    n_idx   = '0;
                    n_chk   = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_chk     = w_issue;
                n_chk_idx = r_idx[AW-1:0];
                n_idx     = w_issue ? r_idx + CW'(1) : r_idx;
                if (w_hit) begin
                    n_member = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    unique case (r_op)
                        OP_INSERT: n_status = ST_PRESENT;
                        OP_REMOVE: n_state  = S_SHIFT;
                        OP_LOOKUP: n_status = ST_OK;
                        OP_CLEAR:  n_count  = '0;
                    endcase
                end else if (w_end) begin
                    n_member = 1'b0;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (r_count >= CAP_C) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ram_we = 1'b1;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        OP_REMOVE: n_status = ST_ABSENT;
                        OP_LOOKUP: n_status = ST_ABSENT;
                        OP_CLEAR:  n_count  = '0;
                    endcase
                end
            end
            S_SHIFT: begin
                n_chk     = w_issue;
                n_chk_idx = r_idx[AW-1:0];
                n_idx     = w_issue ? r_idx + CW'(1) : r_idx;
                // entry read at k lands at k-1
                if (r_chk) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_chk_idx - AW'(1);
                    o_ram_wdata = i_ram_rdata;
                end
                if (w_end) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_res_vld = 1'b1;
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_rdy = (r_state == S_IDLE);

    always_comb begin
        o_res.status        = r_status;
        o_res.is_member     = r_member;
        o_res.element_count = COUNT_FIELD_W'(r_count);
        o_res.is_empty      = (r_count == '0);
    end

endmodule

// ===== rtl/bounded_integer_set.sv =====
`timescale 1ns / 1ps
// Bounded set of distinct integers: insert, remove, lookup, clear.
// One word is in work at a time: a new word is taken only after the result of the last has left
// the sequencer. A remove needs no second pass, the scan and shift together walk the held entries once.
// The pace is set by the single RAM read port feeding the one shared compare. Reset empties
// the set.
module bounded_integer_set
    import bis_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] is_member, [7:1] element_count,
                                        // [8] is_empty, [15:9] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int AW = $clog2(CAPACITY);

    logic                  w_res_vld, w_res_rdy;
    t_result               w_res;
    logic                  w_we;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [VALUE_BITS-1:0] w_wdata, w_rdata;

    logic    r_out_vld;
    t_result r_out;

    bis_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bis_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_vld    (s_axis_tvalid),
        .o_in_rdy    (s_axis_tready),
        .i_opcode    (t_op'(s_axis_tuser)),
        .i_value     (s_axis_tdata),
        .o_res_vld   (w_res_vld),
        .i_res_rdy   (w_res_rdy),
        .o_res       (w_res),
        .o_ram_we    (w_we),
        .o_ram_waddr (w_waddr),
        .o_ram_wdata (w_wdata),
        .o_ram_raddr (w_raddr),
        .i_ram_rdata (w_rdata)
    );

    // output register decouples the sequencer from downstream stalls
    assign w_res_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_rdy) begin
            r_out_vld <= w_res_vld;
        end
        if (w_res_rdy && w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {7'd0, r_out.is_empty, r_out.element_count, r_out.is_member};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous word still in work");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_vld |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    a_full_not_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> !m_axis_tdata[0])
        else $error("full status reported for a member value");

    a_absent_not_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_ABSENT) |-> !m_axis_tdata[0])
        else $error("absent status reported for a member value");
`endif

endmodule

// ===== verif/bounded_integer_set_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bounded_integer_set: a directed table then random set traffic, every result
// word checked against a typed-in reply or a shadow copy of the set. Depends on rtl/bis_pkg.sv and the rtl.
module bounded_integer_set_tb;
    import bis_pkg::*;

    localparam int SET_CAP    = CAPACITY_DEF;
    localparam int ITEMS_PER_PHASE = 270;
    localparam int HOLD_CYCLES     = 600;
    localparam t_result NO_REPLY   = '0;

    typedef struct packed {
        t_op         op;
        logic [31:0] val;
        logic        known;   // reply typed in below, else taken from the shadow set
        t_result     reply;
    } t_row;

    localparam int NUM_ROWS = 22;
    localparam t_row STIM_ROWS [NUM_ROWS] = '{
        '{OP_LOOKUP, 32'h0000_0000, 1'b1, '{ST_ABSENT,  1'b0, 7'd0, 1'b1}},
        '{OP_REMOVE, 32'h8000_0000, 1'b1, '{ST_ABSENT,  1'b0, 7'd0, 1'b1}},
        '{OP_CLEAR,  32'hFFFF_FFFF, 1'b1, '{ST_OK,      1'b0, 7'd0, 1'b1}},
        '{OP_INSERT, 32'h8000_0000, 1'b1, '{ST_OK,      1'b0, 7'd1, 1'b0}},
        '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{ST_OK,      1'b0, 7'd2, 1'b0}},
        '{OP_INSERT, 32'h0000_0000, 1'b1, '{ST_OK,      1'b0, 7'd3, 1'b0}},
        '{OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{ST_OK,      1'b0, 7'd4, 1'b0}},
        '{OP_INSERT, 32'h8000_0000, 1'b1, '{ST_PRESENT, 1'b1, 7'd4, 1'b0}},
        '{OP_LOOKUP, 32'h7FFF_FFFF, 1'b0, NO_REPLY},
        '{OP_LOOKUP, 32'h7FFF_FFFE, 1'b1, '{ST_ABSENT,  1'b0, 7'd4, 1'b0}},
        '{OP_REMOVE, 32'h8000_0000, 1'b0, NO_REPLY},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
        '{OP_REMOVE, 32'h8000_0000, 1'b1, '{ST_ABSENT,  1'b0, 7'd3, 1'b0}},
        '{OP_INSERT, 32'h5555_5555, 1'b0, NO_REPLY},
        '{OP_INSERT, 32'hAAAA_AAAA, 1'b0, NO_REPLY},
        '{OP_REMOVE, 32'hAAAA_AAAA, 1'b0, NO_REPLY},
        '{OP_REMOVE, 32'h7FFF_FFFF, 1'b0, NO_REPLY},
        '{OP_CLEAR,  32'h0000_0000, 1'b0, NO_REPLY},
        '{OP_CLEAR,  32'h1234_5678, 1'b1, '{ST_OK,      1'b0, 7'd0, 1'b1}},
        '{OP_INSERT, 32'h0000_0001, 1'b0, NO_REPLY},
        '{OP_REMOVE, 32'h0000_0001, 1'b0, NO_REPLY},
        '{OP_LOOKUP, 32'h0000_0001, 1'b1, '{ST_ABSENT,  1'b0, 7'd0, 1'b1}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] value
    logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [0] is_member, [7:1] element_count, [8] is_empty
    logic [1:0]  m_axis_tuser;        // [1:0] status

    bounded_integer_set #(
        .CAPACITY   (CAPACITY_DEF),
        .VALUE_BITS (VALUE_BITS_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the set
    logic [31:0] shadow_elems [SET_CAP];
    int          shadow_count = 0;

    t_result replies_due [$];
    int      errors = 0;
    int      items_sent = 0;
    int      tx_idle_pct = 30;
    int      rx_idle_pct = 71;
    bit      rx_hold_start = 1'b0;

    function automatic t_result apply_set_op(t_op op, logic [31:0] val);
        t_result r;
        int      pos;
        bit      held;
        pos = shadow_count;
        for (int i = 0; i < shadow_count; i++) begin
            if (pos == shadow_count && shadow_elems[i] == val) pos = i;
        end
        held = (pos < shadow_count);
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (held) begin
                    r.status = ST_PRESENT;
                end else if (shadow_count >= SET_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_elems[shadow_count] = val;
                    shadow_count++;
                end
            end
            OP_REMOVE: begin
                if (held) begin
                    for (int j = pos; j + 1 < shadow_count; j++)
                        shadow_elems[j] = shadow_elems[j+1];
                    shadow_count--;
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            OP_LOOKUP: r.status = held ? ST_OK : ST_ABSENT;
            default:   shadow_count = 0;
        endcase
        r.is_member     = held;
        r.element_count = shadow_count[COUNT_FIELD_W-1:0];
        r.is_empty      = (shadow_count == 0);
        return r;
    endfunction

    // 0 wide random, 1 a held element, 2 small signed range, 3 extremes
    function automatic logic [31:0] pick_value(int mode);
        logic [31:0] v;
        case (mode)
            1: v = (shadow_count > 0) ? shadow_elems[$urandom_range(shadow_count-1)] : $urandom;
            2: v = 32'($urandom_range(15)) - 32'd8;
            3: begin
                case ($urandom_range(5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h8000_0001;
                    default: v = 32'h7FFF_FFFE;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Called at a clock edge where no input has been assigned yet; returns at the accept edge.
    task automatic send_item(t_op op, logic [31:0] val, logic known, t_result reply);
        t_result r;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        r = apply_set_op(op, val);
        replies_due.push_back(known ? reply : r);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    // Empty the set, fill it to capacity, then poke at the full set.
    task automatic run_fill();
        int roll;
        send_item(OP_CLEAR, pick_value(1), 1'b0, NO_REPLY);
        while (shadow_count < SET_CAP) begin
            if ($urandom_range(9) == 0)
                send_item(OP_INSERT, pick_value(1), 1'b0, NO_REPLY);
            else
                send_item(OP_INSERT, pick_value(0), 1'b0, NO_REPLY);
        end
        repeat (14) begin
            roll = $urandom_range(4);
            case (roll)
                0: send_item(OP_INSERT, pick_value(0), 1'b0, NO_REPLY);
                1: send_item(OP_INSERT, pick_value(1), 1'b0, NO_REPLY);
                2: send_item(OP_LOOKUP, pick_value(1), 1'b0, NO_REPLY);
                3: send_item(OP_REMOVE, pick_value(1), 1'b0, NO_REPLY);
                default: send_item(OP_INSERT, pick_value(3), 1'b0, NO_REPLY);
            endcase
        end
    endtask

    task automatic run_churn(int n, int mode);
        int          roll;
        t_op         op;
        logic [31:0] v;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < 40)      op = OP_INSERT;
            else if (roll < 70) op = OP_REMOVE;
            else if (roll < 96) op = OP_LOOKUP;
            else                op = OP_CLEAR;
            v = ($urandom_range(1) == 0) ? pick_value(1) : pick_value(mode);
            send_item(op, v, 1'b0, NO_REPLY);
        end
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, bit with_hold);
        int start;
        int roll;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = items_sent;
        run_fill();
        if (with_hold) rx_hold_start = 1'b1;
        while (items_sent - start < ITEMS_PER_PHASE) begin
            roll = $urandom_range(99);
            if (roll < 15)      run_fill();
            else if (roll < 55) run_churn(40, 2);
            else if (roll < 85) run_churn(40, 0);
            else                run_churn(20, 3);
        end
        wait_drained();
    endtask

    // receiver side: random stalls, one long hold, reply check
    int rx_hold_left = 0;

    always @(posedge i_clk) begin : reply_check
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status        = t_status'(m_axis_tuser);
            got.is_member     = m_axis_tdata[0];
            got.element_count = m_axis_tdata[7:1];
            got.is_empty      = m_axis_tdata[8];
            if (replies_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: status %0d member %0b count %0d %s %0b",
                             got.status, got.is_member, got.element_count, "empty",
                             got.is_empty);
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status || got.is_member !== want.is_member ||
                    got.element_count !== want.element_count ||
                    got.is_empty !== want.is_empty) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch at %0t: want status %0d member %0b count %0d ",
                                  "empty %0b, got status %0d member %0b count %0d empty %0b"},
                                 $realtime, want.status, want.is_member, want.element_count,
                                 want.is_empty, got.status, got.is_member, got.element_count,
                                 got.is_empty);
                end
            end
        end
        if (rx_hold_left == 0 && rx_hold_start) begin
            rx_hold_left  = HOLD_CYCLES;
            rx_hold_start = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (STIM_ROWS[i])
            send_item(STIM_ROWS[i].op, STIM_ROWS[i].val, STIM_ROWS[i].known, STIM_ROWS[i].reply);
        wait_drained();

        run_phase(30, 71, 1'b1);
        run_phase(71, 30, 1'b0);
        run_phase(0, 0, 1'b0);

        // a result may still be in flight after the queue empties on a stray word
        repeat (SET_CAP + 8) @(posedge i_clk);
        if (replies_due.size() != 0) errors++;
        if (errors == 0)
            $display("bounded_integer_set_tb OK");
        else
            $display("bounded_integer_set_tb NOT OK");
        $finish;
    end

    initial begin
        #(64'd10_000_000);
        $display("bounded_integer_set_tb NOT OK");
        $finish;
    end

endmodule
